// ----- hdl/ffsa_pkg.sv -----
// Shared types and constants for the first-fit segment allocator.
// Depends on nothing; used by ffsa_ram users and the top level.
package ffsa_pkg;

    localparam int ARENA_BYTES   = 1048576;
    localparam int HEADER_BYTES  = 24;
    localparam int ALIGN_BYTES   = 16;
    localparam int MAX_SEGMENTS  = 256;
    localparam int SPLIT_MIN     = 16;

    localparam int FIELD_W = 21;               // width of address/size fields
    localparam int SIZE_W  = 20;               // stored payload size
    localparam int OFF_W   = 22;               // running offset / rounded size
    localparam int AW      = $clog2(MAX_SEGMENTS);
    localparam int IDX_W   = AW + 1;           // index that can hold the count

    // Action codes
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_RESIZE  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR = 2'd2;

    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } seg_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [FIELD_W-1:0] request_bytes;
        logic [FIELD_W-1:0] address;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] address_res;
        logic [FIELD_W-1:0] copy_from;
        logic [FIELD_W-1:0] copy_bytes;
    } rsp_t;

endpackage

// ----- hdl/ffsa_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old contents.
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/first_fit_segment_allocator_top.sv -----
// First-fit segment allocator: sequencer around one segment table RAM.
// Allocate, release and resize walk the table on its single read port; an
// allocate with a split also shifts the entries above it, and a relocating
// resize scans for a fit and then releases the old segment. One transaction
// at a time: the next is accepted in the cycle after the result register
// loads; a held result stalls. After reset the init state writes the
// initial free segment.
module first_fit_segment_allocator_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  ffsa_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output ffsa_pkg::rsp_t  res
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_SHIFT  = 4'd3;
    localparam logic [3:0] S_SPLITW = 4'd4;
    localparam logic [3:0] S_TAKE   = 4'd5;
    localparam logic [3:0] S_ISSUE  = 4'd6;
    localparam logic [3:0] S_MERGE  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam int AW    = ffsa_pkg::AW;
    localparam int IDX_W = ffsa_pkg::IDX_W;
    localparam int OFF_W = ffsa_pkg::OFF_W;
    localparam int SW    = ffsa_pkg::SIZE_W;
    localparam int FW    = ffsa_pkg::FIELD_W;

    localparam logic [OFF_W-1:0] HDR      = OFF_W'(ffsa_pkg::HEADER_BYTES);
    localparam logic [OFF_W-1:0] ALN_M1   = OFF_W'(ffsa_pkg::ALIGN_BYTES - 1);
    localparam logic [OFF_W:0]   SPLIT_AD =
        (OFF_W+1)'(ffsa_pkg::HEADER_BYTES + ffsa_pkg::SPLIT_MIN);
    localparam logic [IDX_W-1:0] MAXS     = IDX_W'(ffsa_pkg::MAX_SEGMENTS);
    localparam logic [SW-1:0]    INIT_SZ  =
        SW'(ffsa_pkg::ARENA_BYTES - ffsa_pkg::HEADER_BYTES);

    // Control and working registers
    logic [3:0]        state_reg, state_next;
    logic              fit_reg, fit_next;         // scan looks for a fit
    logic              reloc_reg, reloc_next;     // resize that moves
    logic              refind_reg, refind_next;   // second lookup of old segment
    logic              split_reg, split_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [AW-1:0]     hit_reg, hit_next;
    logic [AW-1:0]     w_reg, w_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Payload registers
    ffsa_pkg::cmd_t    cmd_reg, cmd_next;
    logic [OFF_W-1:0]  n_reg, n_next;
    logic [SW-1:0]     hsize_reg, hsize_next;
    logic [SW-1:0]     old_reg, old_next;
    ffsa_pkg::seg_t    cur_reg, cur_next;
    ffsa_pkg::rsp_t    rslt_reg, rslt_next;
    ffsa_pkg::rsp_t    rsp_reg, rsp_next;

    // RAM ports
    logic              we;
    logic [AW-1:0]     waddr;
    ffsa_pkg::seg_t    wdata;
    logic [AW-1:0]     raddr;
    ffsa_pkg::seg_t    rdata;

    ffsa_ram #(
        .WIDTH ($bits(ffsa_pkg::seg_t)),
        .DEPTH (ffsa_pkg::MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = rsp_valid_reg;
    assign res       = rsp_reg;

    // Sequencer
    always_comb
    begin
        logic [IDX_W-1:0] idx_inc;
        logic [IDX_W-1:0] idx_dec;
        logic [OFF_W-1:0] round_cmd;
        logic [OFF_W-1:0] size_x;
        logic             fits;
        logic             do_split;
        logic             find_hit;
        ffsa_pkg::seg_t   ent;
        logic [OFF_W-1:0] rest;

        idx_inc   = idx_reg + 1'b1;
        idx_dec   = idx_reg - 1'b1;
        round_cmd = ({1'b0, cmd.request_bytes} + ALN_M1) & ~ALN_M1;
        size_x    = OFF_W'(rdata.size);
        fits      = rdata.free && (size_x >= n_reg);
        do_split  = ({1'b0, size_x} >= ({1'b0, n_reg} + SPLIT_AD)) && (count_reg < MAXS);
        find_hit  = (off_reg == {1'b0, cmd_reg.address});
        ent       = rdata;
        if (idx_reg[AW-1:0] == hit_reg)
        begin
            ent.free = 1'b1;
        end
        rest      = OFF_W'(hsize_reg) - n_reg - HDR;

        state_next     = state_reg;
        fit_next       = fit_reg;
        reloc_next     = reloc_reg;
        refind_next    = refind_reg;
        split_next     = split_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        off_next       = off_reg;
        hit_next       = hit_reg;
        w_next         = w_reg;
        cmd_next       = cmd_reg;
        n_next         = n_reg;
        hsize_next     = hsize_reg;
        old_next       = old_reg;
        cur_next       = cur_reg;
        rslt_next      = rslt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = idx_inc[AW-1:0];

        // Output register drains independently
        if (rsp_valid_reg && res_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                we         = 1'b1;
                wdata.free = 1'b1;
                wdata.size = INIT_SZ;
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                raddr = '0;
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    n_next      = round_cmd;
                    rslt_next   = '0;
                    idx_next    = '0;
                    off_next    = HDR;
                    reloc_next  = 1'b0;
                    refind_next = 1'b0;
                    split_next  = 1'b0;
                    hit_next    = '0;
                    priority if (cmd.action == ffsa_pkg::ACT_ALLOC
                                 || (cmd.action == ffsa_pkg::ACT_RESIZE
                                     && cmd.address == '0))
                    begin
                        fit_next = 1'b1;
                        if (cmd.request_bytes == '0)
                        begin
                            rslt_next.status = ffsa_pkg::ST_NO_FIT;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (cmd.action == ffsa_pkg::ACT_RELEASE
                             || cmd.action == ffsa_pkg::ACT_RESIZE)
                    begin
                        fit_next = 1'b0;
                        if (cmd.address == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // Walk the table in address order, one entry per cycle
            S_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    if (fit_reg)
                    begin
                        rslt_next.status = ffsa_pkg::ST_NO_FIT;
                    end
                    else if (!refind_reg)
                    begin
                        rslt_next.status = ffsa_pkg::ST_BAD_ADDR;
                    end
                    state_next = S_DONE;
                end
                else if (fit_reg && fits)
                begin
                    hit_next              = idx_reg[AW-1:0];
                    hsize_next            = rdata.size;
                    split_next            = do_split;
                    rslt_next.address_res = off_reg[FW-1:0];
                    if (reloc_reg)
                    begin
                        rslt_next.copy_from  = cmd_reg.address;
                        rslt_next.copy_bytes = FW'(old_reg);
                    end
                    if (do_split && (count_reg > idx_inc))
                    begin
                        idx_next   = count_reg - 1'b1;
                        raddr      = idx_next[AW-1:0];
                        state_next = S_SHIFT;
                    end
                    else if (do_split)
                    begin
                        state_next = S_SPLITW;
                    end
                    else
                    begin
                        state_next = S_TAKE;
                    end
                end
                else if (!fit_reg && find_hit)
                begin
                    hit_next = idx_reg[AW-1:0];
                    if (refind_reg || cmd_reg.action == ffsa_pkg::ACT_RELEASE
                        || cmd_reg.request_bytes == '0)
                    begin
                        raddr      = '0;
                        idx_next   = '0;
                        w_next     = '0;
                        state_next = S_MERGE;
                    end
                    else if ({1'b0, rdata.size} >= cmd_reg.request_bytes)
                    begin
                        rslt_next.address_res = cmd_reg.address;
                        state_next            = S_DONE;
                    end
                    else
                    begin
                        old_next   = rdata.size;
                        reloc_next = 1'b1;
                        fit_next   = 1'b1;
                        raddr      = '0;
                        idx_next   = '0;
                        off_next   = HDR;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                    off_next = off_reg + size_x + HDR;
                end
            end

            // Move entries above the split point up by one, top first
            S_SHIFT:
            begin
                we    = 1'b1;
                waddr = idx_inc[AW-1:0];
                wdata = rdata;
                if (idx_reg[AW-1:0] == hit_reg + 1'b1)
                begin
                    state_next = S_SPLITW;
                end
                else
                begin
                    idx_next = idx_dec;
                    raddr    = idx_dec[AW-1:0];
                end
            end

            S_SPLITW:
            begin
                we         = 1'b1;
                waddr      = hit_reg + 1'b1;
                wdata.free = 1'b1;
                wdata.size = rest[SW-1:0];
                state_next = S_TAKE;
            end

            S_TAKE:
            begin
                we         = 1'b1;
                waddr      = hit_reg;
                wdata.free = 1'b0;
                wdata.size = split_reg ? n_reg[SW-1:0] : hsize_reg;
                if (split_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (reloc_reg)
                begin
                    refind_next = 1'b1;
                    fit_next    = 1'b0;
                    state_next  = S_ISSUE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_ISSUE:
            begin
                raddr      = '0;
                idx_next   = '0;
                off_next   = HDR;
                state_next = S_SCAN;
            end

            // Compact the table, folding runs of free segments together
            S_MERGE:
            begin
                if (idx_reg == '0)
                begin
                    cur_next = ent;
                    idx_next = idx_inc;
                end
                else if (idx_reg == count_reg)
                begin
                    we         = 1'b1;
                    waddr      = w_reg;
                    wdata      = cur_reg;
                    count_next = IDX_W'(w_reg) + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    if (cur_reg.free && ent.free)
                    begin
                        cur_next.size = SW'(OFF_W'(cur_reg.size) + HDR + size_x);
                    end
                    else
                    begin
                        we       = 1'b1;
                        waddr    = w_reg;
                        wdata    = cur_reg;
                        w_next   = w_reg + 1'b1;
                        cur_next = ent;
                    end
                    idx_next = idx_inc;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || res_ready)
                begin
                    rsp_next       = rslt_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            fit_reg       <= 1'b0;
            reloc_reg     <= 1'b0;
            refind_reg    <= 1'b0;
            split_reg     <= 1'b0;
            count_reg     <= IDX_W'(1);
            idx_reg       <= '0;
            off_reg       <= '0;
            hit_reg       <= '0;
            w_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fit_reg       <= fit_next;
            reloc_reg     <= reloc_next;
            refind_reg    <= refind_next;
            split_reg     <= split_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            off_reg       <= off_next;
            hit_reg       <= hit_next;
            w_reg         <= w_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        n_reg     <= n_next;
        hsize_reg <= hsize_next;
        old_reg   <= old_next;
        cur_reg   <= cur_next;
        rslt_reg  <= rslt_next;
        rsp_reg   <= rsp_next;
    end

endmodule
